### sv/cfb_pkg.sv
// Shared types and constants for the command frame builder.
`default_nettype none
package cfb_pkg;

  localparam int MAX_PAYLOAD = 240;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] SYNC_BYTE = 8'hA5;
  localparam logic [7:0] LF_BYTE   = 8'h0A;
  localparam logic [7:0] CR_BYTE   = 8'h0D;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ADDRESS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_ADDRESS   = 8'd1;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  localparam logic [2:0] HEADER_LAST  = 3'd6;
  localparam logic [2:0] TRAILER_LAST = 3'd3;

  typedef struct packed {
    logic [7:0] source_address;
    logic [7:0] dest_address;
  } addr_cfg_t;

  typedef enum logic [1:0] {
    JOB_HEADER,
    JOB_PAYLOAD,
    JOB_REJECT
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  ctl_code;
    logic [7:0]  function_code;
    logic [7:0]  last_byte;
    logic        trailer;
    logic [15:0] sum;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HEAD,
    B_DATA,
    B_REJ,
    B_TRAIL
  } back_state_t;

endpackage
`default_nettype wire

### sv/cfb_front.sv
// Front end: accepts input transactions, tracks frame state and queues jobs.
`default_nettype none
module cfb_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfb_pkg::addr_cfg_t cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              opcode,
  input  wire logic [7:0]        ctl_code,
  input  wire logic [7:0]        function_code,
  input  wire logic [7:0]        payload_length,
  input  wire logic [7:0]        payload_byte,
  input  wire logic              queue_full,
  output logic                   push,
  output cfb_pkg::job_t          job
);

  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  bytes_remaining, bytes_remaining_next;
  logic        frame_open, frame_open_next;
  logic        accept;
  logic [15:0] header_sum;
  logic [15:0] payload_sum;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign header_sum = 16'(cfb_pkg::SYNC_BYTE) + 16'(cfb_pkg::SYNC_BYTE)
                    + {8'd0, cfg.source_address} + {8'd0, cfg.dest_address}
                    + {8'd0, ctl_code} + {8'd0, function_code}
                    + {8'd0, payload_length};
  assign payload_sum = running_sum + {8'd0, payload_byte};

  always_comb begin
    running_sum_next     = running_sum;
    bytes_remaining_next = bytes_remaining;
    frame_open_next      = frame_open;
    push                 = 1'b0;
    job.kind             = cfb_pkg::JOB_HEADER;
    job.ctl_code         = ctl_code;
    job.function_code    = function_code;
    job.last_byte        = payload_length;
    job.trailer          = 1'b0;
    job.sum              = header_sum;
    if (accept) begin
      if (opcode == cfb_pkg::OP_START) begin
        push = 1'b1;
        if (payload_length > 8'(cfb_pkg::MAX_PAYLOAD)) begin
          job.kind             = cfb_pkg::JOB_REJECT;
          running_sum_next     = 16'd0;
          bytes_remaining_next = 8'd0;
          frame_open_next      = 1'b0;
        end else if (payload_length == 8'd0) begin
          job.trailer          = 1'b1;
          running_sum_next     = 16'd0;
          bytes_remaining_next = 8'd0;
          frame_open_next      = 1'b0;
        end else begin
          running_sum_next     = header_sum;
          bytes_remaining_next = payload_length;
          frame_open_next      = 1'b1;
        end
      end else if (frame_open && bytes_remaining != 8'd0) begin
        push          = 1'b1;
        job.kind      = cfb_pkg::JOB_PAYLOAD;
        job.last_byte = payload_byte;
        job.sum       = payload_sum;
        if (bytes_remaining == 8'd1) begin
          job.trailer          = 1'b1;
          running_sum_next     = 16'd0;
          bytes_remaining_next = 8'd0;
          frame_open_next      = 1'b0;
        end else begin
          running_sum_next     = payload_sum;
          bytes_remaining_next = bytes_remaining - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= 16'd0;
      bytes_remaining <= 8'd0;
      frame_open      <= 1'b0;
    end else begin
      running_sum     <= running_sum_next;
      bytes_remaining <= bytes_remaining_next;
      frame_open      <= frame_open_next;
    end
  end

endmodule
`default_nettype wire

### sv/cfb_queue.sv
// Short job queue between the front end and the byte serializer.
`default_nettype none
module cfb_queue #(
  parameter int DEPTH = cfb_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cfb_pkg::job_t push_job,
  input  wire logic          pop,
  output cfb_pkg::job_t      head_job,
  output logic               full,
  output logic               empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  cfb_pkg::job_t entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr, rd_ptr_next;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full        = count == CW'(DEPTH);
  assign empty       = count == '0;
  assign do_push     = push && !full;
  assign do_pop      = pop && !empty;
  assign rd_ptr_next = do_pop ? ((rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1)) : rd_ptr;

  // The head entry is kept in a register; a job written to the next head slot is forwarded.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
    if (do_push && (wr_ptr == rd_ptr_next)) begin
      head_job <= push_job;
    end else begin
      head_job <= entries[rd_ptr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      rd_ptr <= rd_ptr_next;
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### sv/cfb_back.sv
// Back end: expands queued jobs into the serialized frame bytes.
`default_nettype none
module cfb_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfb_pkg::addr_cfg_t cfg,
  input  wire cfb_pkg::job_t      head_job,
  input  wire logic               queue_empty,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    frame_end,
  output logic                    rejected
);

  cfb_pkg::back_state_t state, state_next;
  logic [2:0]    idx, idx_next;
  cfb_pkg::job_t job;
  logic          last;
  logic          fire;
  logic [15:0]   checksum;

  assign checksum = (~job.sum) + 16'd1;
  assign fire     = out_valid && out_ready;

  always_comb begin
    out_valid = 1'b0;
    out_byte  = 8'd0;
    frame_end = 1'b0;
    rejected  = 1'b0;
    last      = 1'b0;
    case (state)
      cfb_pkg::B_HEAD: begin
        out_valid = 1'b1;
        last      = (idx == cfb_pkg::HEADER_LAST) && !job.trailer;
        case (idx)
          3'd0, 3'd1: out_byte = cfb_pkg::SYNC_BYTE;
          3'd2:       out_byte = cfg.source_address;
          3'd3:       out_byte = cfg.dest_address;
          3'd4:       out_byte = job.ctl_code;
          3'd5:       out_byte = job.function_code;
          default:    out_byte = job.last_byte;
        endcase
      end
      cfb_pkg::B_DATA: begin
        out_valid = 1'b1;
        out_byte  = job.last_byte;
        last      = !job.trailer;
      end
      cfb_pkg::B_REJ: begin
        out_valid = 1'b1;
        rejected  = 1'b1;
        last      = 1'b1;
      end
      cfb_pkg::B_TRAIL: begin
        out_valid = 1'b1;
        last      = idx == cfb_pkg::TRAILER_LAST;
        case (idx)
          3'd0:    out_byte = checksum[15:8];
          3'd1:    out_byte = checksum[7:0];
          3'd2:    out_byte = cfb_pkg::LF_BYTE;
          default: begin
            out_byte  = cfb_pkg::CR_BYTE;
            frame_end = 1'b1;
          end
        endcase
      end
      default: begin
        out_valid = 1'b0;
      end
    endcase
  end

  assign pop = !queue_empty && ((state == cfb_pkg::B_IDLE) || (fire && last));

  always_comb begin
    state_next = state;
    idx_next   = idx;
    if (pop) begin
      idx_next = 3'd0;
      case (head_job.kind)
        cfb_pkg::JOB_HEADER:  state_next = cfb_pkg::B_HEAD;
        cfb_pkg::JOB_PAYLOAD: state_next = cfb_pkg::B_DATA;
        default:              state_next = cfb_pkg::B_REJ;
      endcase
    end else if (fire) begin
      if (last) begin
        state_next = cfb_pkg::B_IDLE;
      end else if (state == cfb_pkg::B_DATA ||
                   (state == cfb_pkg::B_HEAD && idx == cfb_pkg::HEADER_LAST)) begin
        state_next = cfb_pkg::B_TRAIL;
        idx_next   = 3'd0;
      end else begin
        idx_next = idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfb_pkg::B_IDLE;
      idx   <= 3'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head_job;
    end
  end

endmodule
`default_nettype wire

### sv/command_frame_builder_core.sv
// Top level of the command frame builder: configuration registers and the front, queue and back.
//
// Each start transaction yields a seven byte header and, when its length is zero, the four byte
// trailer; each payload transaction yields its byte and, after the last one, the trailer. A
// length above the maximum yields one rejected result. Output runs at one byte per cycle while
// out_ready is high, set by the serializer in the back end; input is taken in every cycle while
// the job queue has room, and once its QUEUE_DEPTH jobs are full, input waits for the back end
// to pop a job. Payload transactions without trailer pass at one per cycle while out_ready is
// high. Configuration writes are taken at once and must only happen while the block is idle.
`default_nettype none
module command_frame_builder_core #(
  parameter int QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            opcode,
  input  wire logic [7:0]                      ctl_code,
  input  wire logic [7:0]                      function_code,
  input  wire logic [7:0]                      payload_length,
  input  wire logic [7:0]                      payload_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 frame_end,
  output logic                                 rejected
);

  cfb_pkg::addr_cfg_t cfg;
  cfb_pkg::job_t      push_job;
  cfb_pkg::job_t      head_job;
  logic               push;
  logic               pop;
  logic               queue_full;
  logic               queue_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_address <= 8'd1;
      cfg.dest_address   <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == cfb_pkg::REG_SOURCE_ADDRESS) begin
        cfg.source_address <= cfg_data;
      end else if (cfg_index == cfb_pkg::REG_DEST_ADDRESS) begin
        cfg.dest_address <= cfg_data;
      end
    end
  end

  cfb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .ctl_code       (ctl_code),
    .function_code  (function_code),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .queue_full     (queue_full),
    .push           (push),
    .job            (push_job)
  );

  cfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  cfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_job    (head_job),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .frame_end   (frame_end),
    .rejected    (rejected)
  );

endmodule
`default_nettype wire
